// ----- rtl/ple_pkg.sv -----
// Package for the positional list engine.
// Holds field widths, action codes and status codes shared by the interfaces and the core.
// No dependencies.
package ple_pkg;

	localparam int POS_W = 16;
	localparam int VAL_W = 32;
	localparam int CNT_W = 5;
	localparam int IDX_W = 4;

	typedef enum logic [1:0] {
		ACT_INSERT = 2'd0,
		ACT_REMOVE = 2'd1,
		ACT_READ   = 2'd2,
		ACT_FIND   = 2'd3
	} action_t;

	typedef enum logic [2:0] {
		STS_OK       = 3'd0,
		STS_BADPOS   = 3'd1,
		STS_EMPTY    = 3'd2,
		STS_FULL     = 3'd3,
		STS_NOTFOUND = 3'd4
	} status_t;

endpackage

// ----- rtl/ple_cmd_if.sv -----
// Command channel of the positional list engine: valid, ready and one command item.
// Depends on ple_pkg.
interface ple_cmd_if;
	logic                                 valid;
	logic                                 ready;
	ple_pkg::action_t                     action;
	logic signed [ple_pkg::POS_W-1:0]     position;
	logic signed [ple_pkg::VAL_W-1:0]     value_in;

	modport source (output valid, output action, output position, output value_in, input ready);
	modport sink (input valid, input action, input position, input value_in, output ready);
endinterface

// ----- rtl/ple_res_if.sv -----
// Result channel of the positional list engine: valid, ready and one result item.
// Depends on ple_pkg.
interface ple_res_if;
	logic                                 valid;
	logic                                 ready;
	ple_pkg::status_t                     status;
	logic [ple_pkg::CNT_W-1:0]            count;
	logic signed [ple_pkg::VAL_W-1:0]     value_out;
	logic [ple_pkg::IDX_W-1:0]            found_index;

	modport source (output valid, output status, output count, output value_out,
		output found_index, input ready);
	modport sink (input valid, input status, input count, input value_out,
		input found_index, output ready);
endinterface

// ----- rtl/positional_list_engine_core.sv -----
// Positional list engine: an ordered list of signed 32-bit values in a memory with one read
// and one write port.
// Depends on ple_pkg, ple_cmd_if and ple_res_if.
//
// Usage: commands arrive on cmd (insert, remove, read, find) and each gives exactly one
// item on res, which carries a status, the entry count after the command, the removed or
// read value and the index found by a search.
// A small sequencer shares the read and write ports and moves one entry per cycle. An error
// goes straight to the result; read fetches one entry; insert moves the entries from the
// target to the end up by one and then writes the new value; remove moves the entries after
// the target down by one; find compares entries from index 0 until a match or the end.
// The result is loaded into the output register as the sequencer returns to idle.
// cmd.ready is high only while the sequencer is idle; a new command is accepted while the
// previous result still waits in the output register.
// When the receiver stalls, a finished result waits in the sequencer until the output
// register frees up, and no command is taken meanwhile.
// Reset clears the entry count and the control state; memory contents are left as they are
// and are never read before being written. No clearing pass is needed.
module positional_list_engine_core #(
	parameter int CAPACITY = 16
) (
	input  logic           clk,
	input  logic           arst_n,
	ple_cmd_if.sink        cmd,
	ple_res_if.source      res
);
	import ple_pkg::*;

	localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CW = $clog2(CAPACITY + 1);

	typedef enum logic [4:0] {
		ST_IDLE  = 5'b00001,
		ST_SWEEP = 5'b00010,
		ST_PUT   = 5'b00100,
		ST_RDW   = 5'b01000,
		ST_EMIT  = 5'b10000
	} state_t;

	state_t                   state_q;
	action_t                  action_q;
	logic signed [VAL_W-1:0]  val_q;
	logic [CW-1:0]            count_q;
	logic [CW-1:0]            at_q;
	logic [CW-1:0]            ptr_q;
	logic                     pend_s1;
	logic                     first_s1;
	logic [AW-1:0]            dst_s1;
	logic signed [VAL_W-1:0]  rdata_s1;
	logic signed [VAL_W-1:0]  got_q;

	status_t                  rst_status_q;
	logic signed [VAL_W-1:0]  rst_value_q;
	logic [IDX_W-1:0]         rst_index_q;

	logic                     out_valid_q;
	status_t                  out_status_q;
	logic [CNT_W-1:0]         out_count_q;
	logic signed [VAL_W-1:0]  out_value_q;
	logic [IDX_W-1:0]         out_index_q;

	logic signed [VAL_W-1:0]  mem [CAPACITY];

	logic                     accept;
	logic                     pos_m1;
	logic                     pos_bad;
	logic                     pos_ge;
	logic [CW-1:0]            pos_idx;
	logic [CW-1:0]            last_idx;
	logic                     more;
	logic                     hit;
	logic                     ren;
	logic [AW-1:0]            raddr;
	logic                     wen;
	logic [AW-1:0]            waddr;
	logic signed [VAL_W-1:0]  wdata;
	logic [CW-1:0]            read_at;

	assign cmd.ready       = (state_q == ST_IDLE);
	assign accept          = cmd.valid && cmd.ready;
	assign res.valid       = out_valid_q;
	assign res.status      = out_status_q;
	assign res.count       = out_count_q;
	assign res.value_out   = out_value_q;
	assign res.found_index = out_index_q;

	assign pos_m1   = (cmd.position == -POS_W'(1));
	assign pos_bad  = cmd.position[POS_W-1] && !pos_m1;
	assign pos_ge   = !cmd.position[POS_W-1] &&
		({1'b0, cmd.position[POS_W-2:0]} >= POS_W'(count_q));
	assign pos_idx  = CW'(cmd.position[POS_W-2:0]);
	assign last_idx = count_q - CW'(1);
	assign read_at  = pos_m1 ? last_idx : pos_idx;
	assign hit      = pend_s1 && (rdata_s1 == val_q);

	always_comb begin
		more = 1'b0;
		case (action_q)
			ACT_INSERT: more = (ptr_q > at_q);
			ACT_REMOVE: more = (ptr_q < count_q);
			ACT_FIND:   more = (ptr_q < count_q) && !hit;
			default:    more = 1'b0;
		endcase
	end

	always_comb begin
		ren   = 1'b0;
		raddr = AW'(ptr_q);
		wen   = 1'b0;
		waddr = dst_s1;
		wdata = rdata_s1;
		case (state_q)
			ST_IDLE: begin
				ren   = accept && (cmd.action == ACT_READ);
				raddr = AW'(read_at);
			end
			ST_SWEEP: begin
				ren = more;
				if (action_q == ACT_INSERT) begin
					raddr = AW'(ptr_q - CW'(1));
					wen   = pend_s1;
				end else if (action_q == ACT_REMOVE) begin
					wen = pend_s1 && !first_s1;
				end
			end
			ST_PUT: begin
				wen   = 1'b1;
				waddr = AW'(at_q);
				wdata = val_q;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (wen) begin
			mem[waddr] <= wdata;
		end
		if (ren) begin
			rdata_s1 <= mem[raddr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			count_q     <= '0;
			pend_s1     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (state_q == ST_EMIT && (!out_valid_q || res.ready)) begin
				out_valid_q <= 1'b1;
			end else if (res.ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						action_q    <= cmd.action;
						val_q       <= cmd.value_in;
						pend_s1     <= 1'b0;
						rst_value_q <= '0;
						rst_index_q <= '0;
						if (cmd.action == ACT_FIND) begin
							if (count_q == '0) begin
								rst_status_q <= STS_EMPTY;
								state_q      <= ST_EMIT;
							end else begin
								rst_status_q <= STS_OK;
								ptr_q        <= '0;
								state_q      <= ST_SWEEP;
							end
						end else if (pos_bad) begin
							rst_status_q <= STS_BADPOS;
							state_q      <= ST_EMIT;
						end else if (cmd.action == ACT_INSERT) begin
							if (count_q == CW'(CAPACITY)) begin
								rst_status_q <= STS_FULL;
								state_q      <= ST_EMIT;
							end else begin
								rst_status_q <= STS_OK;
								at_q         <= (pos_m1 || pos_ge) ? count_q : pos_idx;
								ptr_q        <= count_q;
								state_q      <= ST_SWEEP;
							end
						end else if (count_q == '0) begin
							rst_status_q <= STS_EMPTY;
							state_q      <= ST_EMIT;
						end else if (cmd.action == ACT_REMOVE) begin
							rst_status_q <= STS_OK;
							at_q         <= (pos_m1 || pos_ge) ? last_idx : pos_idx;
							ptr_q        <= (pos_m1 || pos_ge) ? last_idx : pos_idx;
							state_q      <= ST_SWEEP;
						end else if (pos_ge) begin
							rst_status_q <= STS_BADPOS;
							state_q      <= ST_EMIT;
						end else begin
							rst_status_q <= STS_OK;
							state_q      <= ST_RDW;
						end
					end
				end
				ST_SWEEP: begin
					pend_s1 <= more;
					if (more) begin
						if (action_q == ACT_INSERT) begin
							dst_s1 <= AW'(ptr_q);
							ptr_q  <= ptr_q - CW'(1);
						end else begin
							dst_s1   <= (action_q == ACT_REMOVE) ? AW'(ptr_q - CW'(1)) : AW'(ptr_q);
							first_s1 <= (ptr_q == at_q);
							ptr_q    <= ptr_q + CW'(1);
						end
					end
					if (action_q == ACT_REMOVE && pend_s1 && first_s1) begin
						got_q <= rdata_s1;
					end
					if (action_q == ACT_FIND && hit) begin
						rst_index_q <= IDX_W'(dst_s1);
						state_q     <= ST_EMIT;
					end else if (!more && !pend_s1) begin
						case (action_q)
							ACT_INSERT: state_q <= ST_PUT;
							ACT_REMOVE: begin
								state_q     <= ST_EMIT;
								count_q     <= count_q - CW'(1);
								rst_value_q <= got_q;
							end
							default: begin
								state_q      <= ST_EMIT;
								rst_status_q <= STS_NOTFOUND;
							end
						endcase
					end
				end
				ST_PUT: begin
					count_q <= count_q + CW'(1);
					state_q <= ST_EMIT;
				end
				ST_RDW: begin
					rst_value_q <= rdata_s1;
					state_q     <= ST_EMIT;
				end
				ST_EMIT: begin
					if (!out_valid_q || res.ready) begin
						out_status_q <= rst_status_q;
						out_count_q  <= CNT_W'(count_q);
						out_value_q  <= rst_value_q;
						out_index_q  <= rst_index_q;
						state_q      <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

// ----- verif/positional_list_engine_core_tb.sv -----
// Self-checking testbench for positional_list_engine_core: directed and random list commands.
// A built-in predictor of the list computes each expected result; the monitor compares them.
// Depends on ple_pkg, ple_cmd_if, ple_res_if and positional_list_engine_core.
module positional_list_engine_core_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import ple_pkg::*;

	localparam int CAPACITY = 16;
	localparam int ITEM_TARGET = 1650;
	localparam int CYCLE_LIMIT = 400000;
	localparam int TAIL_CYCLES = 40;

	typedef struct {
		action_t                  act;
		logic signed [POS_W-1:0]  pos;
		logic signed [VAL_W-1:0]  val;
		bit                       drain;
	} list_cmd_t;

	typedef struct {
		status_t                  st;
		logic [CNT_W-1:0]         cnt;
		logic signed [VAL_W-1:0]  vout;
		logic [IDX_W-1:0]         idx;
	} list_res_t;

	logic clk = 1'b0;
	logic arst_n;

	ple_cmd_if cmd_ch();
	ple_res_if res_ch();

	positional_list_engine_core #(.CAPACITY(CAPACITY)) u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd_ch),
		.res    (res_ch)
	);

	list_cmd_t pending_cmds[$];
	list_res_t expected_results[$];
	list_cmd_t in_flight;

	logic signed [VAL_W-1:0] list_vals[CAPACITY];
	int list_len = 0;

	logic signed [VAL_W-1:0] value_pool[8] = '{32'sd0, -32'sd1, 32'h7FFF_FFFF, 32'h8000_0000,
		32'sd1, 32'sd5, 32'sd42, 32'h0001_0000};

	int fail_count = 0;
	int cycle_count = 0;
	int burst_left = 0;
	int gap_left = 0;
	int stall_tick = 0;
	int stall_mode = 0;

	function automatic list_res_t apply_list_cmd(list_cmd_t c);
		list_res_t r;
		int at;
		r.st = STS_OK;
		r.vout = '0;
		r.idx = '0;
		if (c.act == ACT_FIND) begin
			if (list_len == 0) begin
				r.st = STS_EMPTY;
			end else begin
				r.st = STS_NOTFOUND;
				for (int i = 0; i < list_len; i++) begin
					if (list_vals[i] == c.val) begin
						r.st = STS_OK;
						r.idx = i[IDX_W-1:0];
						break;
					end
				end
			end
		end else if (c.pos < -1) begin
			r.st = STS_BADPOS;
		end else if (c.act == ACT_INSERT) begin
			if (list_len >= CAPACITY) begin
				r.st = STS_FULL;
			end else begin
				at = (c.pos == -1 || c.pos >= list_len) ? list_len : int'(c.pos);
				for (int i = list_len; i > at; i--)
					list_vals[i] = list_vals[i-1];
				list_vals[at] = c.val;
				list_len++;
			end
		end else if (list_len == 0) begin
			r.st = STS_EMPTY;
		end else if (c.act == ACT_REMOVE) begin
			at = (c.pos == -1 || c.pos >= list_len) ? list_len - 1 : int'(c.pos);
			r.vout = list_vals[at];
			for (int i = at; i + 1 < list_len; i++)
				list_vals[i] = list_vals[i+1];
			list_len--;
		end else begin
			if (c.pos == -1)
				r.vout = list_vals[list_len-1];
			else if (c.pos >= list_len)
				r.st = STS_BADPOS;
			else
				r.vout = list_vals[int'(c.pos)];
		end
		r.cnt = list_len[CNT_W-1:0];
		return r;
	endfunction

	function automatic logic signed [POS_W-1:0] pick_position();
		int roll;
		roll = $urandom_range(0, 99);
		if (roll < 70)
			return POS_W'($urandom_range(0, CAPACITY + 2) - 1);
		else if (roll < 80)
			return POS_W'($urandom_range(CAPACITY + 2, 32767));
		else if (roll < 90)
			return POS_W'(-int'($urandom_range(2, 32768)));
		else
			return POS_W'($urandom);
	endfunction

	function automatic logic signed [VAL_W-1:0] pick_value();
		if ($urandom_range(0, 9) < 5)
			return value_pool[$urandom_range(0, 7)];
		else
			return VAL_W'($urandom);
	endfunction

	function automatic void add_cmd(action_t act, int pos, logic signed [VAL_W-1:0] val,
		bit drain);
		list_cmd_t c;
		c.act = act;
		c.pos = POS_W'(pos);
		c.val = val;
		c.drain = drain;
		pending_cmds.push_back(c);
	endfunction

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk or negedge arst_n) begin : drive_cmds
		logic next_valid;
		if (!arst_n) begin
			cmd_ch.valid <= 1'b0;
			cmd_ch.action <= ACT_INSERT;
			cmd_ch.position <= '0;
			cmd_ch.value_in <= '0;
			burst_left = 0;
			gap_left = 0;
		end else begin
			if (cmd_ch.valid && cmd_ch.ready)
				expected_results.push_back(apply_list_cmd(in_flight));
			if (!cmd_ch.valid || cmd_ch.ready) begin
				next_valid = 1'b0;
				if (gap_left > 0) begin
					gap_left--;
				end else if (pending_cmds.size() != 0 &&
					!(pending_cmds[0].drain && expected_results.size() != 0)) begin
					in_flight = pending_cmds.pop_front();
					next_valid = 1'b1;
					cmd_ch.action <= in_flight.act;
					cmd_ch.position <= in_flight.pos;
					cmd_ch.value_in <= in_flight.val;
					if (burst_left > 1) begin
						burst_left--;
					end else begin
						burst_left = $urandom_range(1, 30);
						gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
					end
				end
				cmd_ch.valid <= next_valid;
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin : check_results
		list_res_t want;
		if (!arst_n) begin
			res_ch.ready <= 1'b0;
		end else begin
			if (res_ch.valid && res_ch.ready) begin
				if (expected_results.size() == 0) begin
					if (fail_count < 10)
						$display("unexpected result: status=%0d count=%0d value=%0d index=%0d",
							res_ch.status, res_ch.count, res_ch.value_out, res_ch.found_index);
					fail_count++;
				end else begin
					want = expected_results.pop_front();
					if (res_ch.status !== want.st || res_ch.count !== want.cnt ||
						res_ch.value_out !== want.vout || res_ch.found_index !== want.idx) begin
						if (fail_count < 10)
							$display("mismatch: expected %0d/%0d/%0d/%0d got %0d/%0d/%0d/%0d",
								want.st, want.cnt, want.vout, want.idx, res_ch.status,
								res_ch.count, res_ch.value_out, res_ch.found_index);
						fail_count++;
					end
				end
			end
			stall_tick++;
			if (stall_tick % 97 == 0)
				stall_mode = $urandom_range(0, 3);
			case (stall_mode)
				0: res_ch.ready <= 1'b1;
				1: res_ch.ready <= 1'($urandom_range(0, 1));
				2: res_ch.ready <= (stall_tick % 5 == 0);
				default: res_ch.ready <= ($urandom_range(0, 7) == 0);
			endcase
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	initial begin
		list_cmd_t c;
		int phase_kind;
		int phase_len;
		int phase_no;
		int roll;

		arst_n = 1'b0;

		add_cmd(ACT_FIND, 0, 32'sd0, 1'b0);
		add_cmd(ACT_REMOVE, -1, 32'sd0, 1'b0);
		add_cmd(ACT_READ, 0, 32'sd0, 1'b0);
		add_cmd(ACT_INSERT, -2, 32'sd9, 1'b0);
		add_cmd(ACT_REMOVE, -32768, 32'sd0, 1'b0);
		add_cmd(ACT_READ, -2, 32'sd0, 1'b0);
		add_cmd(ACT_INSERT, -1, 32'h7FFF_FFFF, 1'b0);
		add_cmd(ACT_INSERT, 0, 32'h8000_0000, 1'b0);
		add_cmd(ACT_INSERT, 32767, 32'sd0, 1'b0);
		add_cmd(ACT_INSERT, 1, -32'sd1, 1'b0);
		add_cmd(ACT_INSERT, 4, 32'sd5, 1'b0);
		add_cmd(ACT_READ, 0, 32'sd0, 1'b0);
		add_cmd(ACT_READ, -1, 32'sd0, 1'b0);
		add_cmd(ACT_READ, 5, 32'sd0, 1'b0);
		add_cmd(ACT_READ, 32767, 32'sd0, 1'b0);
		add_cmd(ACT_FIND, -32768, -32'sd1, 1'b0);
		add_cmd(ACT_FIND, 3, 32'sd123, 1'b0);
		add_cmd(ACT_INSERT, 2, -32'sd1, 1'b0);
		add_cmd(ACT_FIND, 0, -32'sd1, 1'b0);
		add_cmd(ACT_REMOVE, 32767, 32'sd0, 1'b1);
		add_cmd(ACT_REMOVE, 0, 32'sd0, 1'b0);
		add_cmd(ACT_REMOVE, 1, 32'sd0, 1'b0);
		add_cmd(ACT_REMOVE, 2, 32'sd0, 1'b0);
		add_cmd(ACT_REMOVE, -1, 32'sd0, 1'b0);

		phase_no = 0;
		while (pending_cmds.size() < ITEM_TARGET) begin
			phase_kind = $urandom_range(0, 2);
			phase_len = $urandom_range(30, 80);
			for (int k = 0; k < phase_len; k++) begin
				roll = $urandom_range(0, 99);
				case (phase_kind)
					0: c.act = (roll < 70) ? ACT_INSERT : (roll < 80) ? ACT_REMOVE :
						(roll < 90) ? ACT_READ : ACT_FIND;
					1: c.act = (roll < 65) ? ACT_REMOVE : (roll < 75) ? ACT_INSERT :
						(roll < 88) ? ACT_READ : ACT_FIND;
					default: c.act = (roll < 35) ? ACT_INSERT : (roll < 60) ? ACT_REMOVE :
						(roll < 80) ? ACT_READ : ACT_FIND;
				endcase
				c.pos = pick_position();
				c.val = pick_value();
				c.drain = (k == 0) && (phase_no % 3 == 0);
				pending_cmds.push_back(c);
			end
			phase_no++;
		end

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		do @(posedge clk); while (pending_cmds.size() != 0 || cmd_ch.valid);
		do @(posedge clk); while (expected_results.size() != 0);
		repeat (TAIL_CYCLES) @(posedge clk);

		if (fail_count == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule
